// File: hw/rtl/kdl_pkg.sv
// ----------------------------------------------------------------------------
// kdl_pkg
// Shared types and codes for the keyed doubly linked list core.
// ----------------------------------------------------------------------------
package kdl_pkg;

    localparam logic [2:0] CMD_APPEND  = 3'd0;
    localparam logic [2:0] CMD_PREPEND = 3'd1;
    localparam logic [2:0] CMD_INSERT  = 3'd2;
    localparam logic [2:0] CMD_DELETE  = 3'd3;
    localparam logic [2:0] CMD_UPDATE  = 3'd4;
    localparam logic [2:0] CMD_DUMP    = 3'd5;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_DUP     = 3'd1;
    localparam logic [2:0] ST_MISSING = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] key;
        logic signed [31:0] data;
        logic signed [31:0] anchor_key;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] out_key;
        logic signed [31:0] out_data;
        logic               last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic       load_in;
        logic       search_init;
        logic       search_step;
        logic       save_anchor;
        logic       save_hit;
        logic       alloc;
        logic       link_node;
        logic       link_nbrs;
        logic       unlink;
        logic       update;
        logic       dump_init;
        logic       dump_emit;
        logic       status_emit;
        logic [2:0] status;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic search_end;
        logic hit;
        logic hit_anchor;
        logic full;
        logic head_none;
        logic dump_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: hw/rtl/kdl_datapath.sv
// ----------------------------------------------------------------------------
// kdl_datapath
// Node pool memories, list pointers, search and dump walker, output register.
// ----------------------------------------------------------------------------
module kdl_datapath
    import kdl_pkg::*;
#(
    parameter int NODES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  in_item,
    input  dp_cmd_t   ctl,
    output dp_stat_t  stat,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    localparam int IW = $clog2(NODES + 1);
    localparam int AW = $clog2(NODES);
    localparam logic [IW-1:0] NONE = IW'(NODES);
    localparam logic [IW-1:0] LAST_CNT = IW'(NODES - 1);

    logic signed [31:0] node_key   [NODES];
    logic signed [31:0] node_value [NODES];
    logic [IW-1:0]      node_next  [NODES];
    logic [IW-1:0]      node_prev  [NODES];

    logic [NODES-1:0] used_reg;
    logic [IW-1:0]    head_reg, tail_reg, count_reg;
    logic [IW-1:0]    ptr_reg, steps_reg;
    logic [IW-1:0]    anc_reg, anx_reg, nx_reg, pv_reg, new_reg;
    in_item_t         item_reg;

    logic signed [31:0] rd_key_reg, rd_value_reg;
    logic [IW-1:0]      rd_next_reg, rd_prev_reg;

    logic      out_valid_reg;
    out_item_t out_reg;

    logic [IW-1:0]      free_idx;
    logic               empty;
    logic [IW-1:0]      link_next, link_prev;

    // lowest free node
    always_comb
    begin
        free_idx = NONE;
        for (int i = NODES - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_idx = IW'(i);
            end
        end
    end

    assign empty  = (head_reg == NONE);

    always_comb
    begin
        link_next = NONE;
        link_prev = NONE;
        if (!empty)
        begin
            case (item_reg.cmd)
                CMD_APPEND:  link_prev = tail_reg;
                CMD_PREPEND: link_next = head_reg;
                default:
                begin
                    link_prev = anc_reg;
                    link_next = anx_reg;
                end
            endcase
        end
    end

    assign stat.search_end = (ptr_reg == NONE) || (steps_reg == IW'(NODES));
    assign stat.hit        = (rd_key_reg == item_reg.key);
    assign stat.hit_anchor = (rd_key_reg == item_reg.anchor_key);
    assign stat.full       = &used_reg;
    assign stat.head_none  = empty;
    assign stat.dump_last  = (rd_next_reg == NONE) || (steps_reg == LAST_CNT);
    assign stat.out_free   = !out_valid_reg || out_ready;

    // pool memories, registered read at the walk pointer
    always_ff @(posedge clk)
    begin
        rd_key_reg   <= node_key[ptr_reg[AW-1:0]];
        rd_value_reg <= node_value[ptr_reg[AW-1:0]];
        rd_next_reg  <= node_next[ptr_reg[AW-1:0]];
        rd_prev_reg  <= node_prev[ptr_reg[AW-1:0]];

        if (ctl.link_node)
        begin
            node_key[new_reg[AW-1:0]] <= item_reg.key;
        end

        if (ctl.link_node)
        begin
            node_value[new_reg[AW-1:0]] <= item_reg.data;
        end
        else if (ctl.update)
        begin
            node_value[ptr_reg[AW-1:0]] <= item_reg.data;
        end

        if (ctl.link_node)
        begin
            node_next[new_reg[AW-1:0]] <= link_next;
        end
        else if (ctl.link_nbrs && !empty && item_reg.cmd == CMD_APPEND)
        begin
            node_next[tail_reg[AW-1:0]] <= new_reg;
        end
        else if (ctl.link_nbrs && !empty && item_reg.cmd == CMD_INSERT)
        begin
            node_next[anc_reg[AW-1:0]] <= new_reg;
        end
        else if (ctl.unlink && pv_reg != NONE)
        begin
            node_next[pv_reg[AW-1:0]] <= nx_reg;
        end

        if (ctl.link_node)
        begin
            node_prev[new_reg[AW-1:0]] <= link_prev;
        end
        else if (ctl.link_nbrs && !empty && item_reg.cmd == CMD_PREPEND)
        begin
            node_prev[head_reg[AW-1:0]] <= new_reg;
        end
        else if (ctl.link_nbrs && !empty && item_reg.cmd == CMD_INSERT && anx_reg != NONE)
        begin
            node_prev[anx_reg[AW-1:0]] <= new_reg;
        end
        else if (ctl.unlink && nx_reg != NONE)
        begin
            node_prev[nx_reg[AW-1:0]] <= pv_reg;
        end
    end

    // payload holding registers
    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            item_reg <= in_item;
        end
        if (ctl.save_anchor)
        begin
            anc_reg <= ptr_reg;
            anx_reg <= rd_next_reg;
        end
        if (ctl.save_hit)
        begin
            nx_reg <= rd_next_reg;
            pv_reg <= rd_prev_reg;
        end
        if (ctl.alloc)
        begin
            new_reg <= free_idx;
        end
        if (ctl.status_emit)
        begin
            out_reg <= '{status: ctl.status, out_key: '0, out_data: '0, last: 1'b1};
        end
        else if (ctl.dump_emit)
        begin
            out_reg <= '{status: ST_OK, out_key: rd_key_reg, out_data: rd_value_reg,
                         last: stat.dump_last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            head_reg      <= NONE;
            tail_reg      <= NONE;
            count_reg     <= '0;
            ptr_reg       <= NONE;
            steps_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.search_init || ctl.dump_init)
            begin
                ptr_reg   <= head_reg;
                steps_reg <= '0;
            end
            else if (ctl.search_step || ctl.dump_emit)
            begin
                ptr_reg   <= rd_next_reg;
                steps_reg <= steps_reg + 1'b1;
            end

            if (ctl.link_nbrs)
            begin
                used_reg[new_reg[AW-1:0]] <= 1'b1;
                count_reg <= count_reg + 1'b1;
                if (empty)
                begin
                    head_reg <= new_reg;
                    tail_reg <= new_reg;
                end
                else if (item_reg.cmd == CMD_APPEND)
                begin
                    tail_reg <= new_reg;
                end
                else if (item_reg.cmd == CMD_PREPEND)
                begin
                    head_reg <= new_reg;
                end
                else if (anx_reg == NONE)
                begin
                    tail_reg <= new_reg;
                end
            end
            else if (ctl.unlink)
            begin
                used_reg[ptr_reg[AW-1:0]] <= 1'b0;
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - 1'b1;
                end
                if (pv_reg == NONE)
                begin
                    head_reg <= nx_reg;
                end
                if (nx_reg == NONE)
                begin
                    tail_reg <= pv_reg;
                end
            end

            if (ctl.status_emit || ctl.dump_emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

// File: hw/rtl/kdl_ctrl.sv
// ----------------------------------------------------------------------------
// kdl_ctrl
// Command sequencer: searches, allocation, link updates, dump walk, status.
// ----------------------------------------------------------------------------
module kdl_ctrl
    import kdl_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] in_cmd,
    input  dp_stat_t   stat,
    output dp_cmd_t    ctl
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_AS_ISS  = 4'd1;
    localparam logic [3:0] S_AS_WAIT = 4'd2;
    localparam logic [3:0] S_KS_ISS  = 4'd3;
    localparam logic [3:0] S_KS_WAIT = 4'd4;
    localparam logic [3:0] S_ALLOC   = 4'd5;
    localparam logic [3:0] S_LINK1   = 4'd6;
    localparam logic [3:0] S_LINK2   = 4'd7;
    localparam logic [3:0] S_UNLINK  = 4'd8;
    localparam logic [3:0] S_UPDATE  = 4'd9;
    localparam logic [3:0] S_D_ISS   = 4'd10;
    localparam logic [3:0] S_D_WAIT  = 4'd11;
    localparam logic [3:0] S_STATUS  = 4'd12;

    logic [3:0] state_reg, state_next;
    logic [2:0] cmd_reg, cmd_next;
    logic [2:0] st_reg, st_next;
    logic       is_add;

    assign is_add = (cmd_reg == CMD_APPEND) || (cmd_reg == CMD_PREPEND)
                 || (cmd_reg == CMD_INSERT);
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        st_next    = st_reg;
        ctl        = '0;
        ctl.status = st_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    cmd_next    = in_cmd;
                    case (in_cmd) inside
                        CMD_APPEND, CMD_PREPEND, CMD_DELETE, CMD_UPDATE:
                        begin
                            ctl.search_init = 1'b1;
                            state_next      = S_KS_ISS;
                        end
                        CMD_INSERT:
                        begin
                            ctl.search_init = 1'b1;
                            state_next      = S_AS_ISS;
                        end
                        CMD_DUMP:
                        begin
                            if (stat.head_none)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_STATUS;
                            end
                            else
                            begin
                                ctl.dump_init = 1'b1;
                                state_next    = S_D_ISS;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_AS_ISS:
            begin
                if (stat.search_end)
                begin
                    st_next    = ST_MISSING;
                    state_next = S_STATUS;
                end
                else
                begin
                    state_next = S_AS_WAIT;
                end
            end
            S_AS_WAIT:
            begin
                if (stat.hit_anchor)
                begin
                    ctl.save_anchor = 1'b1;
                    ctl.search_init = 1'b1;
                    state_next      = S_KS_ISS;
                end
                else
                begin
                    ctl.search_step = 1'b1;
                    state_next      = S_AS_ISS;
                end
            end
            S_KS_ISS:
            begin
                if (!stat.search_end)
                begin
                    state_next = S_KS_WAIT;
                end
                else if (is_add)
                begin
                    state_next = S_ALLOC;
                end
                else
                begin
                    st_next    = ST_MISSING;
                    state_next = S_STATUS;
                end
            end
            S_KS_WAIT:
            begin
                if (!stat.hit)
                begin
                    ctl.search_step = 1'b1;
                    state_next      = S_KS_ISS;
                end
                else if (is_add)
                begin
                    st_next    = ST_DUP;
                    state_next = S_STATUS;
                end
                else if (cmd_reg == CMD_DELETE)
                begin
                    ctl.save_hit = 1'b1;
                    state_next   = S_UNLINK;
                end
                else
                begin
                    state_next = S_UPDATE;
                end
            end
            S_ALLOC:
            begin
                if (stat.full)
                begin
                    st_next    = ST_FULL;
                    state_next = S_STATUS;
                end
                else
                begin
                    ctl.alloc  = 1'b1;
                    state_next = S_LINK1;
                end
            end
            S_LINK1:
            begin
                ctl.link_node = 1'b1;
                state_next    = S_LINK2;
            end
            S_LINK2:
            begin
                ctl.link_nbrs = 1'b1;
                st_next       = ST_OK;
                state_next    = S_STATUS;
            end
            S_UNLINK:
            begin
                ctl.unlink = 1'b1;
                st_next    = ST_OK;
                state_next = S_STATUS;
            end
            S_UPDATE:
            begin
                ctl.update = 1'b1;
                st_next    = ST_OK;
                state_next = S_STATUS;
            end
            S_D_ISS:
            begin
                state_next = S_D_WAIT;
            end
            S_D_WAIT:
            begin
                if (stat.out_free)
                begin
                    ctl.dump_emit = 1'b1;
                    state_next    = stat.dump_last ? S_IDLE : S_D_ISS;
                end
            end
            S_STATUS:
            begin
                if (stat.out_free)
                begin
                    ctl.status_emit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cmd_reg   <= CMD_APPEND;
            st_reg    <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            cmd_reg   <= cmd_next;
            st_reg    <= st_next;
        end
    end

endmodule

// File: hw/rtl/keyed_doubly_linked_list_core.sv
// ----------------------------------------------------------------------------
// keyed_doubly_linked_list_core
// Keyed doubly linked list over a fixed node pool with add, delete, update
// and dump commands.
// ----------------------------------------------------------------------------
// One command item is taken at a time. Each key search visits every node in
// S_KS_ISS (registered pool read) and then in S_KS_WAIT (compare). Insert after
// runs an anchor search and then a key search, and adds go on through S_ALLOC
// and the link-write states S_LINK1 and S_LINK2.
// Dump reads each node in S_D_ISS and emits it in S_D_WAIT once the output
// register is free. The output register lets the next item be accepted while
// the last result waits. No clearing pass is needed after reset.
module keyed_doubly_linked_list_core
    import kdl_pkg::*;
#(
    parameter int NODES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    kdl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_cmd   (in_item.cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    kdl_datapath #(.NODES(NODES)) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .ctl       (ctl),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the keyed doubly linked list core. A short table of commands covers
// the corner cases, a pool fill and delete pass follows, then constrained-by-hand
// random commands. Every result is compared field by field with a list predictor kept in the bench.
// ----------------------------------------------------------------------------
module tb_top
    import kdl_pkg::*;
;

    localparam int NODES     = 16;
    localparam int N_RANDOM  = 425;
    localparam int IDLE_LIM  = 4000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    keyed_doubly_linked_list_core #(.NODES(NODES)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
    );

    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor: the list kept as an ordered queue of key/data pairs
    logic signed [31:0] list_keys[$];
    logic signed [31:0] list_data[$];
    out_item_t          pending_results[$];
    int                 errors;
    int                 dumps_done;
    int                 fulls_seen;

    // set by the stimulus process, read by the receiver
    logic               quiet_tail;
    logic               long_hold;

    function automatic int find_pos(input logic signed [31:0] k);
        for (int i = 0; i < list_keys.size(); i++)
            if (list_keys[i] == k)
                return i;
        return -1;
    endfunction

    function automatic out_item_t status_item(input logic [2:0] st);
        out_item_t r;
        r.status   = st;
        r.out_key  = '0;
        r.out_data = '0;
        r.last     = 1'b1;
        return r;
    endfunction

    task automatic predict_list(input in_item_t it);
        int a;
        int p;
        out_item_t r;
        case (it.cmd)
            CMD_APPEND, CMD_PREPEND, CMD_INSERT:
            begin
                a = -1;
                if (it.cmd == CMD_INSERT)
                    a = find_pos(it.anchor_key);
                if (it.cmd == CMD_INSERT && a < 0)
                    pending_results.push_back(status_item(ST_MISSING));
                else if (find_pos(it.key) >= 0)
                    pending_results.push_back(status_item(ST_DUP));
                else if (list_keys.size() >= NODES)
                begin
                    pending_results.push_back(status_item(ST_FULL));
                    fulls_seen++;
                end
                else
                begin
                    if (it.cmd == CMD_APPEND)
                    begin
                        list_keys.push_back(it.key);
                        list_data.push_back(it.data);
                    end
                    else if (it.cmd == CMD_PREPEND)
                    begin
                        list_keys.push_front(it.key);
                        list_data.push_front(it.data);
                    end
                    else
                    begin
                        list_keys.insert(a + 1, it.key);
                        list_data.insert(a + 1, it.data);
                    end
                    pending_results.push_back(status_item(ST_OK));
                end
            end
            CMD_DELETE:
            begin
                p = find_pos(it.key);
                if (p < 0)
                    pending_results.push_back(status_item(ST_MISSING));
                else
                begin
                    list_keys.delete(p);
                    list_data.delete(p);
                    pending_results.push_back(status_item(ST_OK));
                end
            end
            CMD_UPDATE:
            begin
                p = find_pos(it.key);
                if (p < 0)
                    pending_results.push_back(status_item(ST_MISSING));
                else
                begin
                    list_data[p] = it.data;
                    pending_results.push_back(status_item(ST_OK));
                end
            end
            CMD_DUMP:
            begin
                dumps_done++;
                if (list_keys.size() == 0)
                    pending_results.push_back(status_item(ST_EMPTY));
                else
                    for (int i = 0; i < list_keys.size(); i++)
                    begin
                        r.status   = ST_OK;
                        r.out_key  = list_keys[i];
                        r.out_data = list_data[i];
                        r.last     = (i == list_keys.size() - 1);
                        pending_results.push_back(r);
                    end
            end
            default:
            begin
                // unknown command: no result
            end
        endcase
    endtask

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing expected: status %0d key %0d",
                       out_item.status, out_item.out_key);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = pending_results.pop_front();
                if (out_item.status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, out_item.status);
                    errors++;
                end
                if (out_item.out_key !== e.out_key)
                begin
                    $error("out_key: expected %0d, got %0d", e.out_key, out_item.out_key);
                    errors++;
                end
                if (out_item.out_data !== e.out_data)
                begin
                    $error("out_data: expected %0d, got %0d", e.out_data,
                           out_item.out_data);
                    errors++;
                end
                if (out_item.last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, out_item.last);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item
    int idle_cycles;
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM)
        begin
            $display("watchdog expired");
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver with random stall bursts and one long hold-off
    initial
    begin
        int n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                n = $urandom_range(1, 14);
                repeat (n - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // key pool kept small so that hits, duplicates and full pools are common
    function automatic logic signed [31:0] pick_key();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return $urandom;
        if (sel == 1 && list_keys.size() > 0)
            return list_keys[$urandom_range(0, list_keys.size() - 1)];
        case ($urandom_range(0, 3))
            0: return 32'sh8000_0000 + $urandom_range(0, 7);
            1: return 32'sh7fff_fff8 + $urandom_range(0, 7);
            default: return $signed($urandom_range(0, 23)) - 12;
        endcase
    endfunction

    // valid stays up after an accept so that items can follow back to back;
    // it drops only for an idle burst or a drain
    task automatic send_item(input in_item_t it, input bit idle_ok);
        int n;
        if (idle_ok && !quiet_tail && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            n = $urandom_range(1, 14);
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_list(it);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    typedef struct {
        logic [2:0]         cmd;
        logic signed [31:0] key;
        logic signed [31:0] data;
        logic signed [31:0] anchor_key;
        bit                 has_exp;
        logic [2:0]         exp_status;
    } stim_row_t;

    localparam logic signed [31:0] KMIN = 32'sh8000_0000;
    localparam logic signed [31:0] KMAX = 32'sh7fff_ffff;

    stim_row_t directed[] = '{
        '{CMD_DUMP,    0,    0,    0,    1, ST_EMPTY},
        '{CMD_DELETE,  5,    0,    0,    1, ST_MISSING},
        '{CMD_UPDATE,  5,    1,    0,    1, ST_MISSING},
        '{CMD_INSERT,  1,    1,    9,    1, ST_MISSING},
        '{CMD_APPEND,  KMIN, KMAX, KMAX, 1, ST_OK},
        '{CMD_PREPEND, KMAX, KMIN, KMIN, 1, ST_OK},
        '{CMD_APPEND,  KMAX, 3,    0,    1, ST_DUP},
        '{CMD_INSERT,  7,    -1,   KMIN, 1, ST_OK},
        '{CMD_INSERT,  8,    -2,   KMAX, 0, ST_OK},
        '{CMD_INSERT,  7,    0,    KMAX, 1, ST_DUP},
        '{3'd6,        1,    1,    1,    0, ST_OK},
        '{3'd7,        -1,   -1,   -1,   0, ST_OK},
        '{CMD_DUMP,    0,    0,    0,    0, ST_OK},
        '{CMD_UPDATE,  KMIN, -1,   0,    1, ST_OK},
        '{CMD_DELETE,  8,    0,    0,    1, ST_OK},
        '{CMD_DELETE,  KMAX, 0,    0,    1, ST_OK},
        '{CMD_DELETE,  7,    0,    0,    1, ST_OK},
        '{CMD_DUMP,    0,    0,    0,    0, ST_OK},
        '{CMD_DELETE,  KMIN, 0,    0,    1, ST_OK},
        '{CMD_DUMP,    0,    0,    0,    1, ST_EMPTY}
    };

    initial
    begin
        in_item_t it;
        int sel;
        errors     = 0;
        dumps_done = 0;
        fulls_seen = 0;
        quiet_tail = 1'b0;
        long_hold  = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_item    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            it.cmd        = directed[i].cmd;
            it.key        = directed[i].key;
            it.data       = directed[i].data;
            it.anchor_key = directed[i].anchor_key;
            send_item(it, 1'b1);
            // table value must agree with the predictor as a sanity check
            if (directed[i].has_exp &&
                pending_results[pending_results.size() - 1].status
                    !== directed[i].exp_status)
            begin
                $error("status: table expects %0d, predictor %0d",
                       directed[i].exp_status,
                       pending_results[pending_results.size() - 1].status);
                errors++;
            end
        end

        // fill the pool to full with a long output hold-off
        long_hold = 1'b1;
        for (int i = 0; i < NODES + 2; i++)
        begin
            it.cmd = CMD_APPEND;
            it.key = 100 + i;
            it.data = $urandom;
            it.anchor_key = $urandom;
            send_item(it, 1'b0);
        end
        it.cmd = CMD_DUMP;
        send_item(it, 1'b0);
        drain_results();
        for (int i = 0; i < NODES; i++)
        begin
            it.cmd = CMD_DELETE;
            it.key = 100 + ((i * 7) % NODES);
            send_item(it, 1'b1);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM - 60)
                quiet_tail = 1'b1;
            if (n == N_RANDOM / 2)
                drain_results();
            sel = $urandom_range(0, 99);
            it.key        = pick_key();
            it.data       = $urandom;
            it.anchor_key = pick_key();
            if (sel < 2)
                it.cmd = 3'(6 + $urandom_range(0, 1));
            else if (sel < 20)
                it.cmd = CMD_APPEND;
            else if (sel < 34)
                it.cmd = CMD_PREPEND;
            else if (sel < 50)
                it.cmd = CMD_INSERT;
            else if (sel < 72)
                it.cmd = CMD_DELETE;
            else if (sel < 86)
                it.cmd = CMD_UPDATE;
            else
                it.cmd = CMD_DUMP;
            send_item(it, 1'b1);
        end

        drain_results();
        repeat (100) @(posedge clk);
        $display("covered %0d dumps, %0d pool-full refusals, all commands and codes",
                 dumps_done, fulls_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
